[rtl/ecar_pkg.sv]
`default_nettype none

package ecar_pkg;

    localparam int NUM_CELLS_DEF = 128;
    localparam int WORD_BITS_DEF = 64;

    localparam logic [7:0] RULE_RESET  = 8'd200;
    localparam logic [7:0] CELLS_RESET = 8'd100;
    localparam int         MIN_CELLS   = 3;

    // fixed stream and register port widths
    localparam int DATA_BITS     = 64;
    localparam int IDX_BITS      = 4;
    localparam int TDATA_BITS    = 72;
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 8;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_RULE  = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CELLS = 1'd1;

    // boundary cells and rule handed to the word update
    typedef struct packed {
        logic [7:0] rule;
        logic       first_cell;
        logic       wrap_cell;
        logic       prev_last;
        logic       next_first;
    } t_calc_ctl;

endpackage

`default_nettype wire

[rtl/ecar_row_mem.sv]
`default_nettype none

module ecar_row_mem #(
    parameter int NUM_WORDS = 2,
    parameter int WORD_BITS = ecar_pkg::WORD_BITS_DEF,
    parameter int AW        = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [WORD_BITS-1:0] i_wdata,
    input  wire logic [AW-1:0]        i_raddr,
    output logic      [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_valid;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // a word never written reads as all zeros
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

`default_nettype wire

[rtl/ecar_word_calc.sv]
`default_nettype none

module ecar_word_calc #(
    parameter int WORD_BITS = ecar_pkg::WORD_BITS_DEF,
    parameter int XW        = 8
) (
    input  wire logic [WORD_BITS-1:0] i_cur,
    input  wire logic [XW-1:0]        i_base,
    input  wire logic [XW-1:0]        i_count,
    input  wire ecar_pkg::t_calc_ctl  i_ctl,
    output logic      [WORD_BITS-1:0] o_next
);

    logic [WORD_BITS-1:0] left_vec;
    logic [WORD_BITS-1:0] right_vec;

    assign left_vec  = {i_cur[WORD_BITS-2:0], i_ctl.prev_last};
    assign right_vec = {i_ctl.next_first, i_cur[WORD_BITS-1:1]};

    always_comb begin
        logic [XW-1:0] pos;
        logic          l;
        logic          r;
        logic [2:0]    k;
        o_next = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            pos = i_base + XW'(j);
            l = (pos == '0) ? i_ctl.wrap_cell : left_vec[j];
            r = (pos == i_count - XW'(1)) ? i_ctl.first_cell : right_vec[j];
            k = {l, i_cur[j], r};
            o_next[j] = (pos < i_count) ? i_ctl.rule[k] : 1'b0;
        end
    end

endmodule

`default_nettype wire

[rtl/elementary_cellular_automaton_row_top.sv]
`default_nettype none

// Circular row of one-bit cells advanced by an 8-bit rule number. The row is held
// as NUM_CELLS/WORD_BITS packed words in a single-port-write, registered-read
// memory. A load request (tuser 0) writes one word and returns nothing.
// A step request (tuser 1) first sweeps the memory once to pick up the wrap cells,
// then updates one word per cycle in place and sends it out, while the output
// side is ready. Reset clears a valid bit per word; no clearing pass.
// Configuration should be written only while no request is in flight.

module elementary_cellular_automaton_row_top #(
    parameter int NUM_CELLS = ecar_pkg::NUM_CELLS_DEF,
    parameter int WORD_BITS = ecar_pkg::WORD_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    // word_index [3:0], word_data [67:4]
    input  wire logic [ecar_pkg::TDATA_BITS-1:0]      i_s_tdata,
    // req_type
    input  wire logic                                 i_s_tuser,
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    // row_word [63:0], out_word_index [67:64]
    output logic      [ecar_pkg::TDATA_BITS-1:0]      o_m_tdata,
    output logic                                      o_m_tlast,
    input  wire logic                                 i_cfg_we,
    input  wire logic [ecar_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  wire logic [ecar_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int NUM_WORDS = (NUM_CELLS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int XW        = $clog2(NUM_WORDS * WORD_BITS + 1);
    localparam int NW        = (XW > 8) ? XW : 8;
    localparam int JW        = $clog2(WORD_BITS);
    localparam int LAST_BITS = NUM_CELLS - (NUM_WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
    localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);
    localparam int IDX_W     = ecar_pkg::IDX_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIRST,
        S_CALC
    } t_state;

    t_state                r_state;
    logic [7:0]            r_rule;
    logic [7:0]            r_cells;
    logic [AW-1:0]         r_w;
    logic [XW-1:0]         r_base;
    logic [WORD_BITS-1:0]  r_cur;
    logic                  r_prev_last;
    logic                  r_first_cell;
    logic                  r_wrap_cell;
    logic                  r_out_valid;
    logic [WORD_BITS-1:0]  r_out_word;
    logic [IDX_W-1:0]      r_out_idx;
    logic                  r_out_last;

    logic                  s_accept;
    logic                  out_free;
    logic [NW-1:0]         cells_ext;
    logic [XW-1:0]         count;
    logic [XW-1:0]         last_pos;
    logic [XW-1:0]         in_idx_ext;
    logic [WORD_BITS-1:0]  in_word;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [WORD_BITS-1:0]  rd_word;
    logic [WORD_BITS-1:0]  new_word;
    logic [AW+1:0]         addr_p1;
    logic [AW+1:0]         addr_p2;
    logic [AW-1:0]         sat_p1;
    logic [AW-1:0]         sat_p2;
    logic                  wrap_hit;
    logic [JW-1:0]         wrap_bit;
    logic [AW+IDX_W-1:0]   w_ext;
    ecar_pkg::t_calc_ctl   calc_ctl;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    // active cell count, clamped to the legal range
    assign cells_ext = NW'(r_cells);
    always_comb begin
        if (cells_ext < NW'(ecar_pkg::MIN_CELLS)) begin
            count = XW'(ecar_pkg::MIN_CELLS);
        end else if (cells_ext > NW'(NUM_CELLS)) begin
            count = XW'(NUM_CELLS);
        end else begin
            count = XW'(cells_ext);
        end
    end
    assign last_pos = count - XW'(1);

    // load path: drop words past the row and bits past the last cell
    assign in_idx_ext = XW'(i_s_tdata[ecar_pkg::IDX_BITS-1:0]);
    assign in_word    = i_s_tdata[ecar_pkg::IDX_BITS +: WORD_BITS];

    assign addr_p1 = (AW+2)'(r_w) + (AW+2)'(1);
    assign addr_p2 = (AW+2)'(r_w) + (AW+2)'(2);
    assign sat_p1  = (addr_p1 < (AW+2)'(NUM_WORDS)) ? addr_p1[AW-1:0] : '0;
    assign sat_p2  = (addr_p2 < (AW+2)'(NUM_WORDS)) ? addr_p2[AW-1:0] : '0;

    assign wrap_hit = (last_pos >= r_base) && (last_pos < r_base + XW'(WORD_BITS));
    assign wrap_bit = JW'(last_pos - r_base);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_w;
        mem_wdata = new_word;
        mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                mem_waddr = AW'(i_s_tdata[ecar_pkg::IDX_BITS-1:0]);
                mem_wdata = (mem_waddr == LAST_WORD) ? (in_word & LAST_MASK) : in_word;
                mem_we    = s_accept && (i_s_tuser == ecar_pkg::REQ_LOAD)
                            && (in_idx_ext < XW'(NUM_WORDS));
            end
            S_SCAN: begin
                mem_raddr = (r_w == LAST_WORD) ? '0 : sat_p1;
            end
            S_FIRST: begin
                mem_raddr = sat_p1;
            end
            S_CALC: begin
                mem_we    = out_free;
                mem_raddr = out_free ? sat_p2 : sat_p1;
            end
            default: begin
                mem_raddr = '0;
            end
        endcase
    end

    ecar_row_mem #(
        .NUM_WORDS (NUM_WORDS),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_word)
    );

    assign calc_ctl.rule       = r_rule;
    assign calc_ctl.first_cell = r_first_cell;
    assign calc_ctl.wrap_cell  = r_wrap_cell;
    assign calc_ctl.prev_last  = r_prev_last;
    assign calc_ctl.next_first = rd_word[0];

    ecar_word_calc #(
        .WORD_BITS (WORD_BITS),
        .XW        (XW)
    ) u_calc (
        .i_cur   (r_cur),
        .i_base  (r_base),
        .i_count (count),
        .i_ctl   (calc_ctl),
        .o_next  (new_word)
    );

    assign w_ext = (AW+IDX_W)'(r_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rule      <= ecar_pkg::RULE_RESET;
            r_cells     <= ecar_pkg::CELLS_RESET;
            r_out_valid <= 1'b0;
            r_w         <= '0;
            r_base      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == ecar_pkg::CFG_RULE) begin
                    r_rule <= i_cfg_data;
                end else if (i_cfg_addr == ecar_pkg::CFG_CELLS) begin
                    r_cells <= i_cfg_data;
                end
            end
            // the word update refills the output register itself
            if (r_out_valid && i_m_tready && (r_state != S_CALC)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_accept && (i_s_tuser == ecar_pkg::REQ_STEP)) begin
                        r_w     <= '0;
                        r_base  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // sweep the old row for cell zero and the cell at the wrap point
                    if (r_w == '0) begin
                        r_first_cell <= rd_word[0];
                    end
                    if (wrap_hit) begin
                        r_wrap_cell <= rd_word[wrap_bit];
                    end
                    if (r_w == LAST_WORD) begin
                        r_w     <= '0;
                        r_base  <= '0;
                        r_state <= S_FIRST;
                    end else begin
                        r_w    <= r_w + AW'(1);
                        r_base <= r_base + XW'(WORD_BITS);
                    end
                end
                S_FIRST: begin
                    r_cur   <= rd_word;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_word  <= new_word;
                        r_out_idx   <= w_ext[IDX_W-1:0];
                        r_out_last  <= (r_w == LAST_WORD);
                        r_prev_last <= r_cur[WORD_BITS-1];
                        r_cur       <= rd_word;
                        r_base      <= r_base + XW'(WORD_BITS);
                        if (r_w == LAST_WORD) begin
                            r_w     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_w <= r_w + AW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {{(ecar_pkg::TDATA_BITS - ecar_pkg::DATA_BITS - IDX_W){1'b0}},
                         r_out_idx,
                         ecar_pkg::DATA_BITS'(r_out_word)};

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int NUM_CELLS     = ecar_pkg::NUM_CELLS_DEF;
    localparam int WORD_BITS     = ecar_pkg::WORD_BITS_DEF;
    localparam int NUM_WORDS     = (NUM_CELLS + WORD_BITS - 1) / WORD_BITS;
    localparam int DATA_BITS     = ecar_pkg::DATA_BITS;
    localparam int IDX_BITS      = ecar_pkg::IDX_BITS;
    localparam int TDATA_BITS    = ecar_pkg::TDATA_BITS;
    localparam int CFG_ADDR_BITS = ecar_pkg::CFG_ADDR_BITS;
    localparam int CFG_DATA_BITS = ecar_pkg::CFG_DATA_BITS;
    localparam int MIN_CELLS     = ecar_pkg::MIN_CELLS;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [DATA_BITS-1:0] word;
        logic [IDX_BITS-1:0]  idx;
        logic                 last;
    } t_row_word;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    logic [TDATA_BITS-1:0]    i_s_tdata;
    logic                     i_s_tuser;
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    logic [TDATA_BITS-1:0]    o_m_tdata;
    logic                     o_m_tlast;
    logic                     i_cfg_we;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    // predictor state
    logic [NUM_CELLS-1:0] cells_now;
    logic [7:0]           rule_reg;
    logic [7:0]           cells_reg;
    t_row_word            pending_words[$];

    int  mismatches;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  quiet_cycles;
    bit  running;

    elementary_cellular_automaton_row_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(negedge i_clk) begin
        i_m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each emitted word with the oldest pending one
    always @(posedge i_clk) begin
        t_row_word exp_w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual data %h last %b",
                         $realtime, o_m_tdata, o_m_tlast);
                mismatches++;
            end else begin
                exp_w = pending_words.pop_front();
                if (o_m_tdata[DATA_BITS-1:0] !== exp_w.word) begin
                    $display("%0t: row_word mismatch: expected %h actual %h",
                             $realtime, exp_w.word, o_m_tdata[DATA_BITS-1:0]);
                    mismatches++;
                end
                if (o_m_tdata[DATA_BITS +: IDX_BITS] !== exp_w.idx) begin
                    $display("%0t: out_word_index mismatch: expected %0d actual %0d",
                             $realtime, exp_w.idx, o_m_tdata[DATA_BITS +: IDX_BITS]);
                    mismatches++;
                end
                if (o_m_tlast !== exp_w.last) begin
                    $display("%0t: last_word mismatch: expected %b actual %b",
                             $realtime, exp_w.last, o_m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!running || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL elementary_cellular_automaton_row_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic req, input logic [IDX_BITS-1:0] idx,
                                input logic [DATA_BITS-1:0] data);
        logic [NUM_CELLS-1:0] nxt;
        t_row_word            rw;
        int                   n;
        int                   pos;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser  = req;
        i_s_tdata  = {{(TDATA_BITS - DATA_BITS - IDX_BITS){1'b0}}, data, idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);

        if (req == ecar_pkg::REQ_LOAD) begin
            // bits past the end of the row are dropped
            for (int j = 0; j < WORD_BITS; j++) begin
                pos = int'(idx) * WORD_BITS + j;
                if (pos < NUM_CELLS) cells_now[pos] = data[j];
            end
        end else begin
            n = int'(cells_reg);
            if (n < MIN_CELLS) n = MIN_CELLS;
            if (n > NUM_CELLS) n = NUM_CELLS;
            nxt = '0;
            for (int i = 0; i < n; i++) begin
                nxt[i] = rule_reg[{cells_now[(i + n - 1) % n], cells_now[i],
                                   cells_now[(i + 1) % n]}];
            end
            cells_now = nxt;
            for (int w = 0; w < NUM_WORDS; w++) begin
                rw.word = '0;
                for (int j = 0; j < WORD_BITS; j++) begin
                    pos = w * WORD_BITS + j;
                    if (pos < NUM_CELLS) rw.word[j] = cells_now[pos];
                end
                rw.idx  = w[IDX_BITS-1:0];
                rw.last = (w == NUM_WORDS - 1);
                pending_words = {pending_words, rw};
            end
        end
    endtask

    // stop sending and let every pending word drain, then let the block settle
    task automatic wait_until_drained();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_BITS-1:0] addr,
                                  input logic [CFG_DATA_BITS-1:0] data);
        wait_until_drained();
        i_cfg_we   = 1'b1;
        i_cfg_addr = addr;
        i_cfg_data = data;
        if (addr == ecar_pkg::CFG_RULE) rule_reg = data;
        else cells_reg = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic test_reset_defaults();
        // zero row under the reset rule, then wrap at the reset cell count
        send_request(ecar_pkg::REQ_STEP, 4'd0, '0);
        send_request(ecar_pkg::REQ_LOAD, 4'd0, 64'h0000_0000_0000_0003);
        send_request(ecar_pkg::REQ_LOAD, 4'd1, 64'h0004_000C_0000_0000);
        send_request(ecar_pkg::REQ_STEP, 4'd0, '0);
    endtask

    task automatic test_small_rows();
        write_register(ecar_pkg::CFG_RULE, 8'd30);
        write_register(ecar_pkg::CFG_CELLS, 8'd3);
        send_request(ecar_pkg::REQ_LOAD, 4'd0, 64'hFFFF_FFFF_FFFF_FFFE);
        send_request(ecar_pkg::REQ_LOAD, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ecar_pkg::REQ_STEP, 4'd0, '0);
        send_request(ecar_pkg::REQ_STEP, 4'd0, '0);
        // below the minimum count
        write_register(ecar_pkg::CFG_RULE, 8'd90);
        write_register(ecar_pkg::CFG_CELLS, 8'd0);
        send_request(ecar_pkg::REQ_LOAD, 4'd0, 64'h0000_0000_0000_0001);
        send_request(ecar_pkg::REQ_STEP, 4'd0, '0);
    endtask

    task automatic test_full_rows();
        // above the row size, and a load that falls past the row
        write_register(ecar_pkg::CFG_RULE, 8'd255);
        write_register(ecar_pkg::CFG_CELLS, 8'd255);
        send_request(ecar_pkg::REQ_LOAD, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ecar_pkg::REQ_STEP, 4'd0, '0);
        write_register(ecar_pkg::CFG_RULE, 8'd0);
        send_request(ecar_pkg::REQ_STEP, 4'd0, '0);
        write_register(ecar_pkg::CFG_RULE, 8'd110);
        write_register(ecar_pkg::CFG_CELLS, 8'd128);
        send_request(ecar_pkg::REQ_LOAD, 4'd0, 64'h8000_0000_0000_0001);
        send_request(ecar_pkg::REQ_LOAD, 4'd1, 64'h8000_0000_0000_0000);
        send_request(ecar_pkg::REQ_STEP, 4'd0, '0);
        send_request(ecar_pkg::REQ_STEP, 4'd0, '0);
    endtask

    task automatic test_word_boundary();
        write_register(ecar_pkg::CFG_RULE, 8'd150);
        write_register(ecar_pkg::CFG_CELLS, 8'd64);
        send_request(ecar_pkg::REQ_LOAD, 4'd1, {$urandom, $urandom});
        send_request(ecar_pkg::REQ_LOAD, 4'd2, {$urandom, $urandom});
        send_request(ecar_pkg::REQ_LOAD, 4'd0, {$urandom, $urandom});
        send_request(ecar_pkg::REQ_STEP, 4'd0, '0);
        write_register(ecar_pkg::CFG_CELLS, 8'd65);
        send_request(ecar_pkg::REQ_STEP, 4'd0, '0);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        logic [CFG_DATA_BITS-1:0] count_sel;
        logic [DATA_BITS-1:0]     data;
        logic [IDX_BITS-1:0]      idx;
        write_register(ecar_pkg::CFG_RULE, 8'($urandom_range(255)));
        case ($urandom_range(5))
            0: count_sel = 8'd3;
            1: count_sel = 8'd128;
            2: count_sel = 8'($urandom_range(0, 2));
            3: count_sel = 8'($urandom_range(129, 255));
            default: count_sel = 8'($urandom_range(3, 128));
        endcase
        write_register(ecar_pkg::CFG_CELLS, count_sel);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++) begin
            if (k == n_items / 2) wait_until_drained();
            data = {$urandom, $urandom};
            if ($urandom_range(2) == 0) data = data & {$urandom, $urandom} & {$urandom, $urandom};
            idx = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1));
            send_request(($urandom_range(99) < 45) ? ecar_pkg::REQ_LOAD : ecar_pkg::REQ_STEP,
                         idx, data);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tuser      = 1'b0;
        i_s_tdata      = '0;
        i_m_tready     = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = '0;
        i_cfg_data     = '0;
        cells_now      = '0;
        rule_reg       = ecar_pkg::RULE_RESET;
        cells_reg      = ecar_pkg::CELLS_RESET;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        running        = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        running = 1'b1;

        test_reset_defaults();
        test_small_rows();
        test_full_rows();
        test_word_boundary();
        test_random_traffic(0, 0, 32);
        test_random_traffic(55, 0, 32);
        test_random_traffic(0, 55, 32);
        test_random_traffic(27, 27, 32);

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS elementary_cellular_automaton_row_top");
        end else begin
            $display("FAIL elementary_cellular_automaton_row_top");
        end
        $finish;
    end

endmodule
